### src/source_tokenizer_defines.svh
// Assertion helpers for the source tokenizer.
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

// Check an implication on every rising clock edge outside reset.
`define ST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("source_tokenizer: check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("source_tokenizer: check failed");

`endif

### src/stok_pkg.sv
package stok_pkg;

  localparam int unsigned OffsetBits   = 24;
  localparam int unsigned KeywordChars = 9;
  localparam int unsigned KwLenBits    = $clog2(KeywordChars + 1);
  localparam int unsigned NumKeywords  = 24;
  localparam logic [15:0] PosMax       = 16'hFFFF;

  typedef logic [OffsetBits-1:0] off_t;
  typedef logic [KwLenBits-1:0]  kwlen_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_IDENT_COLON, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC,
    M_STRING, M_STRING_ESC, M_COLON, M_MINUS, M_SLASH, M_LINE_SKIP,
    M_BLOCK, M_BLOCK_STAR, M_ERROR
  } mode_t;

  localparam logic [5:0] T_IDENT  = 6'd0;
  localparam logic [5:0] T_NUMBER = 6'd1;
  localparam logic [5:0] T_STRING = 6'd2;
  localparam logic [5:0] T_DCOLON = 6'd3;
  localparam logic [5:0] T_COLON  = 6'd4;
  localparam logic [5:0] T_DOT    = 6'd13;
  localparam logic [5:0] T_ARROW  = 6'd19;
  localparam logic [5:0] T_MINUS  = 6'd20;
  localparam logic [5:0] T_SLASH  = 6'd21;
  localparam logic [5:0] T_KW0    = 6'd28;
  localparam logic [5:0] T_EOF    = 6'd52;
  localparam logic [5:0] T_ERROR  = 6'd53;
  localparam logic [5:0] T_NONE   = 6'd63;

  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_CHAR   = 2'd1;
  localparam logic [1:0] E_BLOCK  = 2'd2;
  localparam logic [1:0] E_STRING = 2'd3;

  typedef struct packed {
    logic [5:0]  token_type;
    logic [1:0]  error_code;
    logic [23:0] tok_offset;
    logic [23:0] token_length;
    logic [15:0] tok_line;
    logic [15:0] tok_column;
  } tok_t;

  typedef logic [7:0] kwbuf_t [KeywordChars];

  function automatic logic [5:0] punct_type(input logic [7:0] c);
    logic [5:0] t;
    unique case (c)
      8'h3B: t = 6'd5;  8'h2C: t = 6'd6;  8'h28: t = 6'd7;  8'h29: t = 6'd8;
      8'h7B: t = 6'd9;  8'h7D: t = 6'd10; 8'h5B: t = 6'd11; 8'h5D: t = 6'd12;
      8'h2E: t = 6'd13; 8'h3C: t = 6'd14; 8'h3E: t = 6'd15; 8'h26: t = 6'd16;
      8'h2A: t = 6'd17; 8'h2B: t = 6'd18; 8'h25: t = 6'd22; 8'h7C: t = 6'd23;
      8'h5E: t = 6'd24; 8'h21: t = 6'd25; 8'h3F: t = 6'd26; 8'h3D: t = 6'd27;
      default: t = T_NONE;
    endcase
    return t;
  endfunction

  function automatic logic [8*KeywordChars-1:0] kw_text(input int unsigned i);
    logic [8*KeywordChars-1:0] s;
    unique case (i)
      0: s = "return";  1: s = "if";      2: s = "else";      3: s = "for";
      4: s = "while";   5: s = "do";      6: s = "assert";    7: s = "pre";
      8: s = "post";    9: s = "using";   10: s = "namespace"; 11: s = "type";
      12: s = "public"; 13: s = "protected"; 14: s = "private"; 15: s = "virtual";
      16: s = "override"; 17: s = "final"; 18: s = "in";      19: s = "inout";
      20: s = "out";    21: s = "copy";   22: s = "move";     23: s = "forward";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic kwlen_t kw_len(input int unsigned i);
    kwlen_t n;
    unique case (i)
      0, 6, 12: n = kwlen_t'(6);
      1, 5, 18: n = kwlen_t'(2);
      2, 8, 11, 21, 22: n = kwlen_t'(4);
      3, 7, 20: n = kwlen_t'(3);
      4, 9, 17, 19: n = kwlen_t'(5);
      10, 13: n = kwlen_t'(9);
      14, 15, 23: n = kwlen_t'(7);
      16: n = kwlen_t'(8);
      default: n = '0;
    endcase
    return n;
  endfunction

  // Strings are right-aligned: character k of a word of length n sits at byte n-1-k.
  function automatic logic [5:0] kw_lookup(input kwbuf_t buf_i, input kwlen_t n);
    logic [5:0] t;
    logic [8*KeywordChars-1:0] s;
    logic hit;
    t = T_IDENT;
    for (int i = NumKeywords - 1; i >= 0; i--) begin
      s = kw_text(i);
      hit = (kw_len(i) == n);
      for (int k = 0; k < KeywordChars; k++) begin
        if (k < int'(n) && s[8*(int'(n)-1-k) +: 8] != buf_i[k]) hit = 1'b0;
      end
      if (hit) t = T_KW0 + 6'(i);
    end
    return t;
  endfunction

endpackage

### src/source_tokenizer.sv
// Channel | Direction | Payload
// in_     | slave     | tdata: char_code[7:0]; tuser: kind
// out_    | master    | tdata: token_type, error_code, offsets, line, column; tlast
// One input transaction is accepted per cycle while the result stage is free.
// An input produces up to three results; they are held in a three-entry
// result queue and drained one per cycle while out_tready is high, and the
// next input is accepted as the last result of the previous one leaves.
// Reset (rst_n low, synchronous) returns the scanner to the idle position 1:1.
// out_tready low holds the queue; in_tready drops only while it holds results.
`include "source_tokenizer_defines.svh"

module source_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code[7:0]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // token_type[5:0], error_code[7:6],
                                  // tok_offset[31:8], token_length[55:32],
                                  // tok_line[71:56], tok_column[87:72]
  output logic        out_tlast   // last_of_run
);

  // Scanner state
  stok_pkg::mode_t  mode_r, mode_nxt;
  stok_pkg::off_t   cur_off_r, cur_off_nxt, ts_off_r, ts_off_nxt;
  logic [15:0]      cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [15:0]      ts_line_r, ts_line_nxt, ts_col_r, ts_col_nxt;
  stok_pkg::kwbuf_t kw_r, kw_nxt;
  stok_pkg::kwlen_t wlen_r, wlen_nxt;
  logic             wovf_r, wovf_nxt;

  // Result queue: holds the results of one transaction
  stok_pkg::tok_t   q_r [3];
  stok_pkg::tok_t   q_nxt [3];
  logic [1:0]       qcnt_r, qhead_r, ncnt;

  logic in_fire, out_fire;
  logic [7:0] c;
  logic is_alpha, is_digit, is_blank;
  stok_pkg::off_t len, len1;
  logic [5:0] ident_t;

  assign in_tready = (qcnt_r == 2'd0) || (out_fire && (qhead_r + 2'd1 == qcnt_r));
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (qcnt_r != 2'd0);
  assign out_fire  = out_tvalid && out_tready;
  assign out_tdata = {q_r[qhead_r].tok_column, q_r[qhead_r].tok_line,
                      q_r[qhead_r].token_length, q_r[qhead_r].tok_offset,
                      q_r[qhead_r].error_code, q_r[qhead_r].token_type};
  assign out_tlast = (qhead_r + 2'd1 == qcnt_r);

  assign c = in_tdata;
  assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit = (c >= 8'h30 && c <= 8'h39);
  assign is_blank = (c == 8'h20) || (c == 8'h0D) || (c == 8'h09) || (c == 8'h0A);
  assign len  = cur_off_r - ts_off_r;
  assign len1 = len - stok_pkg::off_t'(1);
  assign ident_t = wovf_r ? stok_pkg::T_IDENT : stok_pkg::kw_lookup(kw_r, wlen_r);

  function automatic logic [15:0] sat_add(input logic [15:0] a, input stok_pkg::off_t b);
    logic [32:0] s;
    s = 33'(a) + 33'(b);
    return (s > 33'(stok_pkg::PosMax)) ? stok_pkg::PosMax : s[15:0];
  endfunction

  always_comb begin
    stok_pkg::tok_t t;
    logic start;
    logic [5:0] p;
    mode_nxt = mode_r; cur_off_nxt = cur_off_r; cur_line_nxt = cur_line_r;
    cur_col_nxt = cur_col_r; ts_off_nxt = ts_off_r; ts_line_nxt = ts_line_r;
    ts_col_nxt = ts_col_r; kw_nxt = kw_r; wlen_nxt = wlen_r; wovf_nxt = wovf_r;
    ncnt = 2'd0;
    start = 1'b0;
    p = stok_pkg::punct_type(c);
    t = '0;
    for (int i = 0; i < 3; i++) q_nxt[i] = q_r[i];

    // End of input: flush any open token, emit EOF and return to position 1:1
    if (in_tuser) begin
      unique case (mode_r)
        stok_pkg::M_IDENT: begin
          q_nxt[0] = '{ident_t, stok_pkg::E_NONE, 24'(ts_off_r), 24'(len), ts_line_r, ts_col_r};
          ncnt = 2'd1;
        end
        stok_pkg::M_IDENT_COLON, stok_pkg::M_NUM_DOT: begin
          q_nxt[0] = '{(mode_r == stok_pkg::M_IDENT_COLON) ? ident_t : stok_pkg::T_NUMBER,
                       stok_pkg::E_NONE, 24'(ts_off_r), 24'(len1), ts_line_r, ts_col_r};
          q_nxt[1] = '{(mode_r == stok_pkg::M_IDENT_COLON) ? stok_pkg::T_COLON : stok_pkg::T_DOT,
                       stok_pkg::E_NONE, 24'(ts_off_r + len1), 24'd1, ts_line_r,
                       sat_add(ts_col_r, len1)};
          ncnt = 2'd2;
        end
        stok_pkg::M_NUM_INT, stok_pkg::M_NUM_FRAC: begin
          q_nxt[0] = '{stok_pkg::T_NUMBER, stok_pkg::E_NONE, 24'(ts_off_r), 24'(len),
                       ts_line_r, ts_col_r};
          ncnt = 2'd1;
        end
        stok_pkg::M_STRING, stok_pkg::M_STRING_ESC, stok_pkg::M_BLOCK,
        stok_pkg::M_BLOCK_STAR: begin
          q_nxt[0] = '{stok_pkg::T_ERROR,
                       (mode_r == stok_pkg::M_STRING || mode_r == stok_pkg::M_STRING_ESC)
                         ? stok_pkg::E_STRING : stok_pkg::E_BLOCK,
                       24'(ts_off_r), 24'(len), ts_line_r, ts_col_r};
          ncnt = 2'd1;
        end
        stok_pkg::M_COLON, stok_pkg::M_MINUS, stok_pkg::M_SLASH: begin
          q_nxt[0] = '{(mode_r == stok_pkg::M_COLON) ? stok_pkg::T_COLON :
                       (mode_r == stok_pkg::M_MINUS) ? stok_pkg::T_MINUS : stok_pkg::T_SLASH,
                       stok_pkg::E_NONE, 24'(ts_off_r), 24'd1, ts_line_r, ts_col_r};
          ncnt = 2'd1;
        end
        default: ncnt = 2'd0;
      endcase
      q_nxt[ncnt] = '{stok_pkg::T_EOF, stok_pkg::E_NONE, 24'(cur_off_r), 24'd0,
                      cur_line_r, cur_col_r};
      ncnt = ncnt + 2'd1;
      mode_nxt = stok_pkg::M_IDLE; cur_off_nxt = '0; cur_line_nxt = 16'd1;
      cur_col_nxt = 16'd1; ts_off_nxt = '0; ts_line_nxt = 16'd1; ts_col_nxt = 16'd1;
      wlen_nxt = '0; wovf_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        stok_pkg::M_IDENT: begin
          if (is_alpha || is_digit || c == 8'h5F || c == 8'h24) begin
            if (wlen_r < stok_pkg::kwlen_t'(stok_pkg::KeywordChars)) begin
              kw_nxt[wlen_r[$clog2(stok_pkg::KeywordChars)-1:0]] = c;
              wlen_nxt = wlen_r + stok_pkg::kwlen_t'(1);
            end else wovf_nxt = 1'b1;
          end else if (c == 8'h3A) begin
            mode_nxt = stok_pkg::M_IDENT_COLON;
          end else begin
            q_nxt[0] = '{ident_t, stok_pkg::E_NONE, 24'(ts_off_r), 24'(len), ts_line_r, ts_col_r};
            ncnt = 2'd1; start = 1'b1;
          end
        end
        stok_pkg::M_IDENT_COLON: begin
          if (c == 8'h3A) begin
            // Two colon characters enter the word as far as room allows; overflow marks it
            if (wlen_r + stok_pkg::kwlen_t'(2) <= stok_pkg::kwlen_t'(stok_pkg::KeywordChars)) begin
              kw_nxt[wlen_r[$clog2(stok_pkg::KeywordChars)-1:0]] = 8'h3A;
              kw_nxt[4'(wlen_r + stok_pkg::kwlen_t'(1))] = 8'h3A;
              wlen_nxt = wlen_r + stok_pkg::kwlen_t'(2);
            end else if (wlen_r < stok_pkg::kwlen_t'(stok_pkg::KeywordChars)) begin
              kw_nxt[wlen_r[$clog2(stok_pkg::KeywordChars)-1:0]] = 8'h3A;
              wlen_nxt = wlen_r + stok_pkg::kwlen_t'(1);
              wovf_nxt = 1'b1;
            end else wovf_nxt = 1'b1;
            mode_nxt = stok_pkg::M_IDENT;
          end else begin
            q_nxt[0] = '{ident_t, stok_pkg::E_NONE, 24'(ts_off_r), 24'(len1), ts_line_r, ts_col_r};
            q_nxt[1] = '{stok_pkg::T_COLON, stok_pkg::E_NONE, 24'(ts_off_r + len1), 24'd1,
                         ts_line_r, sat_add(ts_col_r, len1)};
            ncnt = 2'd2; start = 1'b1;
          end
        end
        stok_pkg::M_NUM_INT: begin
          if (c == 8'h2E) mode_nxt = stok_pkg::M_NUM_DOT;
          else if (!is_digit) begin
            q_nxt[0] = '{stok_pkg::T_NUMBER, stok_pkg::E_NONE, 24'(ts_off_r), 24'(len),
                         ts_line_r, ts_col_r};
            ncnt = 2'd1; start = 1'b1;
          end
        end
        stok_pkg::M_NUM_DOT: begin
          if (is_digit) mode_nxt = stok_pkg::M_NUM_FRAC;
          else begin
            q_nxt[0] = '{stok_pkg::T_NUMBER, stok_pkg::E_NONE, 24'(ts_off_r), 24'(len1),
                         ts_line_r, ts_col_r};
            q_nxt[1] = '{stok_pkg::T_DOT, stok_pkg::E_NONE, 24'(ts_off_r + len1), 24'd1,
                         ts_line_r, sat_add(ts_col_r, len1)};
            ncnt = 2'd2; start = 1'b1;
          end
        end
        stok_pkg::M_NUM_FRAC: begin
          if (!is_digit) begin
            q_nxt[0] = '{stok_pkg::T_NUMBER, stok_pkg::E_NONE, 24'(ts_off_r), 24'(len),
                         ts_line_r, ts_col_r};
            ncnt = 2'd1; start = 1'b1;
          end
        end
        stok_pkg::M_STRING: begin
          if (c == 8'h22) begin
            q_nxt[0] = '{stok_pkg::T_STRING, stok_pkg::E_NONE, 24'(ts_off_r),
                         24'(len + stok_pkg::off_t'(1)), ts_line_r, ts_col_r};
            ncnt = 2'd1; mode_nxt = stok_pkg::M_IDLE;
          end else if (c == 8'h5C) mode_nxt = stok_pkg::M_STRING_ESC;
        end
        stok_pkg::M_STRING_ESC: mode_nxt = stok_pkg::M_STRING;
        stok_pkg::M_COLON, stok_pkg::M_MINUS: begin
          if ((mode_r == stok_pkg::M_COLON && c == 8'h3A) ||
              (mode_r == stok_pkg::M_MINUS && c == 8'h3E)) begin
            q_nxt[0] = '{(mode_r == stok_pkg::M_COLON) ? stok_pkg::T_DCOLON : stok_pkg::T_ARROW,
                         stok_pkg::E_NONE, 24'(ts_off_r), 24'd2, ts_line_r, ts_col_r};
            ncnt = 2'd1; mode_nxt = stok_pkg::M_IDLE;
          end else begin
            q_nxt[0] = '{(mode_r == stok_pkg::M_COLON) ? stok_pkg::T_COLON : stok_pkg::T_MINUS,
                         stok_pkg::E_NONE, 24'(ts_off_r), 24'd1, ts_line_r, ts_col_r};
            ncnt = 2'd1; start = 1'b1;
          end
        end
        stok_pkg::M_SLASH: begin
          if (c == 8'h2F) mode_nxt = stok_pkg::M_LINE_SKIP;
          else if (c == 8'h2A) mode_nxt = stok_pkg::M_BLOCK;
          else begin
            q_nxt[0] = '{stok_pkg::T_SLASH, stok_pkg::E_NONE, 24'(ts_off_r), 24'd1,
                         ts_line_r, ts_col_r};
            ncnt = 2'd1; start = 1'b1;
          end
        end
        stok_pkg::M_LINE_SKIP: if (c == 8'h0A) mode_nxt = stok_pkg::M_IDLE;
        stok_pkg::M_BLOCK: if (c == 8'h2A) mode_nxt = stok_pkg::M_BLOCK_STAR;
        stok_pkg::M_BLOCK_STAR: begin
          if (c == 8'h2F) mode_nxt = stok_pkg::M_IDLE;
          else if (c != 8'h2A) mode_nxt = stok_pkg::M_BLOCK;
        end
        stok_pkg::M_ERROR: mode_nxt = stok_pkg::M_ERROR;
        default: start = 1'b1;
      endcase

      // Token boundary: open a new token at this byte
      if (start) begin
        ts_off_nxt = cur_off_r; ts_line_nxt = cur_line_r; ts_col_nxt = cur_col_r;
        mode_nxt = stok_pkg::M_IDLE;
        t = '{p, stok_pkg::E_NONE, 24'(cur_off_r), 24'd1, cur_line_r, cur_col_r};
        if (is_blank) begin
          mode_nxt = stok_pkg::M_IDLE;
        end else if (p != stok_pkg::T_NONE) begin
          q_nxt[ncnt] = t; ncnt = ncnt + 2'd1;
        end else if (c == 8'h23) mode_nxt = stok_pkg::M_LINE_SKIP;
        else if (c == 8'h2F) mode_nxt = stok_pkg::M_SLASH;
        else if (c == 8'h3A) mode_nxt = stok_pkg::M_COLON;
        else if (c == 8'h2D) mode_nxt = stok_pkg::M_MINUS;
        else if (c == 8'h22) mode_nxt = stok_pkg::M_STRING;
        else if (is_alpha || c == 8'h5F) begin
          kw_nxt[0] = c; wlen_nxt = stok_pkg::kwlen_t'(1); wovf_nxt = 1'b0;
          mode_nxt = stok_pkg::M_IDENT;
        end else if (is_digit) mode_nxt = stok_pkg::M_NUM_INT;
        else begin
          t.token_type = stok_pkg::T_ERROR; t.error_code = stok_pkg::E_CHAR;
          q_nxt[ncnt] = t; ncnt = ncnt + 2'd1;
          mode_nxt = stok_pkg::M_ERROR;
        end
      end

      // Advance position
      cur_off_nxt = cur_off_r + stok_pkg::off_t'(1);
      if (c == 8'h0A) begin
        cur_line_nxt = sat_add(cur_line_r, stok_pkg::off_t'(1));
        cur_col_nxt = 16'd1;
      end else cur_col_nxt = sat_add(cur_col_r, stok_pkg::off_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stok_pkg::M_IDLE;
      cur_off_r <= '0; cur_line_r <= 16'd1; cur_col_r <= 16'd1;
      ts_off_r <= '0; ts_line_r <= 16'd1; ts_col_r <= 16'd1;
      wlen_r <= '0; wovf_r <= 1'b0;
      qcnt_r <= 2'd0; qhead_r <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_r <= mode_nxt; cur_off_r <= cur_off_nxt; cur_line_r <= cur_line_nxt;
        cur_col_r <= cur_col_nxt; ts_off_r <= ts_off_nxt; ts_line_r <= ts_line_nxt;
        ts_col_r <= ts_col_nxt; wlen_r <= wlen_nxt; wovf_r <= wovf_nxt;
        qcnt_r <= ncnt; qhead_r <= 2'd0;
      end else if (out_fire) begin
        if (qhead_r + 2'd1 == qcnt_r) begin
          qcnt_r <= 2'd0; qhead_r <= 2'd0;
        end else qhead_r <= qhead_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kw_r <= kw_nxt;
      for (int i = 0; i < 3; i++) q_r[i] <= q_nxt[i];
    end
  end

  `ST_ASSERT_IMP(a_head_in_range, out_tvalid, qhead_r < qcnt_r)
  `ST_ASSERT_IMP(a_end_gives_result, in_fire && in_tuser, ncnt != 2'd0)
  `ST_ASSERT_NEXT(a_end_resets_pos, in_fire && in_tuser, cur_off_r == '0 && cur_line_r == 16'd1)
  `ST_ASSERT_IMP(a_err_type, out_tvalid && out_tdata[7:6] != stok_pkg::E_NONE,
                 out_tdata[5:0] == stok_pkg::T_ERROR)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tlast;

  source_tokenizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // char_code
    .in_tuser(in_tuser),   // kind
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), // type, error, offset, length, line, column
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  typedef struct {
    stok_pkg::tok_t tok;
    logic last;
  } token_rec_t;

  token_rec_t pending_tokens[$];
  int         n_errors = 0;
  int         n_items = 0;
  longint     cycle_count = 0;
  bit         in_busy = 1'b0;

  // Scanner shadow state
  stok_pkg::mode_t sc_mode;
  logic [23:0] sc_off, sc_tok_off;
  logic [15:0] sc_line, sc_col, sc_tok_line, sc_tok_col;
  logic [7:0]  sc_word [stok_pkg::KeywordChars];
  int          sc_wlen;
  bit          sc_wover;
  token_rec_t  step_toks[$];

  localparam int LIMIT_CYCLES = 400000;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string what);
    n_errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [23:0] n);
    int unsigned s;
    s = int'(v) + int'(n);
    return s > 65535 ? 16'hFFFF : 16'(s);
  endfunction

  function automatic void push_tok(input logic [5:0] ty, input logic [1:0] ec,
                                   input logic [23:0] off, input logic [23:0] len,
                                   input logic [15:0] ln, input logic [15:0] co);
    token_rec_t r;
    r.tok.token_type = ty;   r.tok.error_code = ec;
    r.tok.tok_offset = off;  r.tok.token_length = len;
    r.tok.tok_line = ln;     r.tok.tok_column = co;
    r.last = 1'b0;
    if (step_toks.size() < 3) step_toks.push_back(r);
  endfunction

  function automatic void push_at_start(input logic [5:0] ty, input logic [1:0] ec,
                                        input logic [23:0] len);
    push_tok(ty, ec, sc_tok_off, len, sc_tok_line, sc_tok_col);
  endfunction

  // Keyword match on the collected word; anything too long stays an identifier
  function automatic logic [5:0] word_type();
    string kw [24] = '{"return", "if", "else", "for", "while", "do", "assert",
      "pre", "post", "using", "namespace", "type", "public", "protected",
      "private", "virtual", "override", "final", "in", "inout", "out",
      "copy", "move", "forward"};
    bit hit;
    if (sc_wover) return stok_pkg::T_IDENT;
    for (int i = 0; i < 24; i++) begin
      if (kw[i].len() == sc_wlen) begin
        hit = 1'b1;
        for (int k = 0; k < sc_wlen; k++)
          if (kw[i][k] != sc_word[k]) hit = 1'b0;
        if (hit) return stok_pkg::T_KW0 + 6'(i);
      end
    end
    return stok_pkg::T_IDENT;
  endfunction

  function automatic void word_add(input logic [7:0] c);
    if (sc_wlen < stok_pkg::KeywordChars) begin
      sc_word[sc_wlen] = c;
      sc_wlen++;
    end else begin
      sc_wover = 1'b1;
    end
  endfunction

  function automatic void push_follower(input logic [5:0] ty, input logic [23:0] len);
    push_tok(ty, stok_pkg::E_NONE, sc_tok_off + len, 24'd1, sc_tok_line,
             sat_inc(sc_tok_col, len));
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void scanner_reset();
    sc_mode = stok_pkg::M_IDLE;
    sc_off = '0; sc_tok_off = '0;
    sc_line = 16'd1; sc_col = 16'd1; sc_tok_line = 16'd1; sc_tok_col = 16'd1;
    foreach (sc_word[k]) sc_word[k] = '0;
    sc_wlen = 0; sc_wover = 1'b0;
  endfunction

  function automatic void begin_token(input logic [7:0] c);
    logic [5:0] p;
    sc_tok_off = sc_off; sc_tok_line = sc_line; sc_tok_col = sc_col;
    sc_mode = stok_pkg::M_IDLE;
    if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) return;
    p = stok_pkg::punct_type(c);
    if (p != stok_pkg::T_NONE) push_at_start(p, stok_pkg::E_NONE, 24'd1);
    else if (c == "#") sc_mode = stok_pkg::M_LINE_SKIP;
    else if (c == "/") sc_mode = stok_pkg::M_SLASH;
    else if (c == ":") sc_mode = stok_pkg::M_COLON;
    else if (c == "-") sc_mode = stok_pkg::M_MINUS;
    else if (c == 8'h22) sc_mode = stok_pkg::M_STRING;
    else if (is_alpha(c) || c == "_") begin
      sc_wlen = 0; sc_wover = 1'b0;
      word_add(c);
      sc_mode = stok_pkg::M_IDENT;
    end else if (is_digit(c)) sc_mode = stok_pkg::M_NUM_INT;
    else begin
      push_at_start(stok_pkg::T_ERROR, stok_pkg::E_CHAR, 24'd1);
      sc_mode = stok_pkg::M_ERROR;
    end
  endfunction

  // Work out the tokens one input transaction produces and queue them
  function automatic void scan_item(input logic kind, input logic [7:0] c);
    logic [23:0] len, len1;
    step_toks.delete();
    len = sc_off - sc_tok_off;
    len1 = len - 24'd1;
    if (kind) begin
      case (sc_mode)
        stok_pkg::M_IDENT: push_at_start(word_type(), stok_pkg::E_NONE, len);
        stok_pkg::M_IDENT_COLON: begin
          push_at_start(word_type(), stok_pkg::E_NONE, len1);
          push_follower(stok_pkg::T_COLON, len1);
        end
        stok_pkg::M_NUM_INT, stok_pkg::M_NUM_FRAC:
          push_at_start(stok_pkg::T_NUMBER, stok_pkg::E_NONE, len);
        stok_pkg::M_NUM_DOT: begin
          push_at_start(stok_pkg::T_NUMBER, stok_pkg::E_NONE, len1);
          push_follower(stok_pkg::T_DOT, len1);
        end
        stok_pkg::M_STRING, stok_pkg::M_STRING_ESC:
          push_at_start(stok_pkg::T_ERROR, stok_pkg::E_STRING, len);
        stok_pkg::M_BLOCK, stok_pkg::M_BLOCK_STAR:
          push_at_start(stok_pkg::T_ERROR, stok_pkg::E_BLOCK, len);
        stok_pkg::M_COLON: push_at_start(stok_pkg::T_COLON, stok_pkg::E_NONE, 24'd1);
        stok_pkg::M_MINUS: push_at_start(stok_pkg::T_MINUS, stok_pkg::E_NONE, 24'd1);
        stok_pkg::M_SLASH: push_at_start(stok_pkg::T_SLASH, stok_pkg::E_NONE, 24'd1);
        default: ;
      endcase
      push_tok(stok_pkg::T_EOF, stok_pkg::E_NONE, sc_off, 24'd0, sc_line, sc_col);
      scanner_reset();
    end else begin
      case (sc_mode)
        stok_pkg::M_IDENT:
          if (is_alpha(c) || is_digit(c) || c == "_" || c == "$") word_add(c);
          else if (c == ":") sc_mode = stok_pkg::M_IDENT_COLON;
          else begin
            push_at_start(word_type(), stok_pkg::E_NONE, len);
            begin_token(c);
          end
        stok_pkg::M_IDENT_COLON:
          if (c == ":") begin
            word_add(":"); word_add(":");
            sc_mode = stok_pkg::M_IDENT;
          end else begin
            push_at_start(word_type(), stok_pkg::E_NONE, len1);
            push_follower(stok_pkg::T_COLON, len1);
            begin_token(c);
          end
        stok_pkg::M_NUM_INT:
          if (c == ".") sc_mode = stok_pkg::M_NUM_DOT;
          else if (!is_digit(c)) begin
            push_at_start(stok_pkg::T_NUMBER, stok_pkg::E_NONE, len);
            begin_token(c);
          end
        stok_pkg::M_NUM_DOT:
          if (is_digit(c)) sc_mode = stok_pkg::M_NUM_FRAC;
          else begin
            push_at_start(stok_pkg::T_NUMBER, stok_pkg::E_NONE, len1);
            push_follower(stok_pkg::T_DOT, len1);
            begin_token(c);
          end
        stok_pkg::M_NUM_FRAC:
          if (!is_digit(c)) begin
            push_at_start(stok_pkg::T_NUMBER, stok_pkg::E_NONE, len);
            begin_token(c);
          end
        stok_pkg::M_STRING:
          if (c == 8'h22) begin
            push_at_start(stok_pkg::T_STRING, stok_pkg::E_NONE, len + 24'd1);
            sc_mode = stok_pkg::M_IDLE;
          end else if (c == 8'h5C) sc_mode = stok_pkg::M_STRING_ESC;
        stok_pkg::M_STRING_ESC: sc_mode = stok_pkg::M_STRING;
        stok_pkg::M_COLON:
          if (c == ":") begin
            push_at_start(stok_pkg::T_DCOLON, stok_pkg::E_NONE, 24'd2);
            sc_mode = stok_pkg::M_IDLE;
          end else begin
            push_at_start(stok_pkg::T_COLON, stok_pkg::E_NONE, 24'd1);
            begin_token(c);
          end
        stok_pkg::M_MINUS:
          if (c == ">") begin
            push_at_start(stok_pkg::T_ARROW, stok_pkg::E_NONE, 24'd2);
            sc_mode = stok_pkg::M_IDLE;
          end else begin
            push_at_start(stok_pkg::T_MINUS, stok_pkg::E_NONE, 24'd1);
            begin_token(c);
          end
        stok_pkg::M_SLASH:
          if (c == "/") sc_mode = stok_pkg::M_LINE_SKIP;
          else if (c == "*") sc_mode = stok_pkg::M_BLOCK;
          else begin
            push_at_start(stok_pkg::T_SLASH, stok_pkg::E_NONE, 24'd1);
            begin_token(c);
          end
        stok_pkg::M_LINE_SKIP: if (c == 8'h0A) sc_mode = stok_pkg::M_IDLE;
        stok_pkg::M_BLOCK: if (c == "*") sc_mode = stok_pkg::M_BLOCK_STAR;
        stok_pkg::M_BLOCK_STAR:
          if (c == "/") sc_mode = stok_pkg::M_IDLE;
          else if (c != "*") sc_mode = stok_pkg::M_BLOCK;
        stok_pkg::M_ERROR: ;
        default: begin_token(c);
      endcase
      sc_off = sc_off + 24'd1;
      if (c == 8'h0A) begin
        sc_line = sat_inc(sc_line, 24'd1);
        sc_col = 16'd1;
      end else begin
        sc_col = sat_inc(sc_col, 24'd1);
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
  endfunction

  // Pick a gap: mostly none, sometimes short, rarely long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one transaction, hold until accepted, then predict
  task automatic send_item(input logic kind, input logic [7:0] c);
    int g;
    g = in_busy ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= c;
    in_busy = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
    scan_item(kind, c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  // Receiver: random stalls, check each accepted result against the oldest
  initial begin
    token_rec_t     e;
    stok_pkg::tok_t got;
    int             g;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid) begin
        got.token_type   = out_tdata[5:0];
        got.error_code   = out_tdata[7:6];
        got.tok_offset   = out_tdata[31:8];
        got.token_length = out_tdata[55:32];
        got.tok_line     = out_tdata[71:56];
        got.tok_column   = out_tdata[87:72];
        if (pending_tokens.size() == 0) begin
          report($sformatf("unexpected token type %0d", got.token_type));
        end else begin
          e = pending_tokens.pop_front();
          if (got.token_type !== e.tok.token_type)
            report($sformatf("type %0d, want %0d", got.token_type, e.tok.token_type));
          if (got.error_code !== e.tok.error_code)
            report($sformatf("error code %0d, want %0d", got.error_code, e.tok.error_code));
          if (got.tok_offset !== e.tok.tok_offset)
            report($sformatf("offset %0d, want %0d", got.tok_offset, e.tok.tok_offset));
          if (got.token_length !== e.tok.token_length)
            report($sformatf("length %0d, want %0d", got.token_length, e.tok.token_length));
          if (got.tok_line !== e.tok.tok_line)
            report($sformatf("line %0d, want %0d", got.tok_line, e.tok.tok_line));
          if (got.tok_column !== e.tok.tok_column)
            report($sformatf("column %0d, want %0d", got.tok_column, e.tok.tok_column));
          if (out_tlast !== e.last)
            report($sformatf("tlast %0b, want %0b", out_tlast, e.last));
        end
      end
    end
  end

  typedef struct {
    logic           kind;
    logic [7:0]     c;
    bit             fixed;   // expected result typed in below
    stok_pkg::tok_t want;
  } stim_row_t;

  function automatic stok_pkg::tok_t mk(input logic [5:0] ty, input logic [1:0] ec,
                                        input logic [23:0] off, input logic [23:0] len,
                                        input logic [15:0] ln, input logic [15:0] co);
    stok_pkg::tok_t t;
    t.token_type = ty; t.error_code = ec; t.tok_offset = off;
    t.token_length = len; t.tok_line = ln; t.tok_column = co;
    return t;
  endfunction

  // Random fragments: mostly well-formed source, some noise
  task automatic send_fragment();
    string frags [] = '{"return", "namespace", "protected", "forward", "inout",
      "a::b", "std::vector", "x$y", "abcdefghijk", "x:", "12", "3.25", "7.",
      "\"str\"", "\"a\\\"b\"", "::", "->", "-", ":", "/", "// note\n",
      "/* c */", "/**/", "# pragma\n", "\n", " ", "\t", "\r", "(){}[];,",
      "<>&*+%|^!?=.", "if", "else", "while", "do", "copy", "move", "final"};
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) send_text(frags[$urandom_range(0, frags.size() - 1)]);
    else if (r < 88) send_item(1'b0, 8'($urandom_range(0, 255)));
    else if (r < 94) send_item(1'b0, 8'($urandom_range(32, 126)));
    else send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    int        sent;
    scanner_reset();
    // Directed rows: EOF at reset, extreme bytes, errors and open constructs
    row = '{1'b1, 8'hFF, 1'b1,
            mk(stok_pkg::T_EOF, stok_pkg::E_NONE, 24'd0, 24'd0, 16'd1, 16'd1)};
    rows.push_back(row);
    row = '{1'b0, 8'h00, 1'b1,
            mk(stok_pkg::T_ERROR, stok_pkg::E_CHAR, 24'd0, 24'd1, 16'd1, 16'd1)};
    rows.push_back(row);
    row = '{1'b0, 8'h41, 1'b0, '0}; rows.push_back(row);  // ignored after error
    row = '{1'b1, 8'h00, 1'b1,
            mk(stok_pkg::T_EOF, stok_pkg::E_NONE, 24'd2, 24'd0, 16'd1, 16'd3)};
    rows.push_back(row);
    row = '{1'b0, 8'hFF, 1'b1,
            mk(stok_pkg::T_ERROR, stok_pkg::E_CHAR, 24'd0, 24'd1, 16'd1, 16'd1)};
    rows.push_back(row);
    row = '{1'b1, 8'h00, 1'b0, '0}; rows.push_back(row);
    row = '{1'b0, "/", 1'b0, '0}; rows.push_back(row);
    row = '{1'b0, "*", 1'b0, '0}; rows.push_back(row);
    row = '{1'b1, 8'h00, 1'b0, '0}; rows.push_back(row);  // open block comment
    row = '{1'b0, 8'h22, 1'b0, '0}; rows.push_back(row);
    row = '{1'b0, 8'h5C, 1'b0, '0}; rows.push_back(row);
    row = '{1'b1, 8'h00, 1'b0, '0}; rows.push_back(row);  // open string
    row = '{1'b0, "9", 1'b0, '0}; rows.push_back(row);
    row = '{1'b0, ".", 1'b0, '0}; rows.push_back(row);
    row = '{1'b0, "x", 1'b0, '0}; rows.push_back(row);    // number, dot; ident opens
    row = '{1'b0, ":", 1'b0, '0}; rows.push_back(row);
    row = '{1'b0, "-", 1'b0, '0}; rows.push_back(row);    // ident, colon; minus opens
    row = '{1'b0, ">", 1'b0, '0}; rows.push_back(row);
    row = '{1'b1, 8'h00, 1'b0, '0}; rows.push_back(row);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_item(rows[i].kind, rows[i].c);
      if (rows[i].fixed && (pending_tokens.size() == 0 ||
          pending_tokens[pending_tokens.size()-1].tok !== rows[i].want))
        report($sformatf("directed row %0d disagrees with table", i));
    end
    // Every keyword and a long identifier, then flush
    send_text("return if else for while do assert pre post using namespace type ");
    send_text("public protected private virtual override final in inout out copy ");
    send_text("move forward namespacex a::b::c _$9 ");
    send_item(1'b1, 8'h00);

    // Hold the sender until everything in flight has drained
    in_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);

    sent = 0;
    while (n_items < 250) begin
      send_fragment();
      sent++;
      if (sent % 8 == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
    end
    send_item(1'b1, 8'h00);
    in_tvalid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/stok_pkg.sv
src/source_tokenizer.sv
tb/sv/tb.sv
